// ----- rtl/lane_tracking_error_macros.svh -----
// Assertion macros for the lane tracking error block.
// Included by files that carry concurrent assertions; expects clk and rst_n in scope.
`ifndef LANE_TRACKING_ERROR_MACROS_SVH
`define LANE_TRACKING_ERROR_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define LTE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LTE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/lte_pkg.sv -----
// Shared types, constants and the arctangent table of the lane tracking error block.
// No dependencies; imported by lte_core and lane_tracking_error.
`timescale 1ns / 1ps

package lte_pkg;

  localparam int unsigned NORM_STAGES  = 5;
  localparam int unsigned ROOT_STAGES  = 32;
  localparam int unsigned CORDIC_STEPS = 28;
  localparam int unsigned DIV_STAGES   = 32;
  localparam int unsigned PIPE_DEPTH   = 2 + (NORM_STAGES + 1) + ROOT_STAGES + (DIV_STAGES + 1);

  localparam logic signed [31:0] Q28_PI      = 32'sd843314857;
  localparam logic signed [31:0] Q28_HALF_PI = 32'sd421657428;
  localparam logic [31:0]        LAT_INVALID  = 32'd655360000;
  localparam logic [31:0]        HEAD_INVALID = 32'h7FFF_FFFF;

  localparam logic [2:0] REG_L0_A    = 3'd0;
  localparam logic [2:0] REG_L0_B    = 3'd1;
  localparam logic [2:0] REG_L0_C    = 3'd2;
  localparam logic [2:0] REG_L1_A    = 3'd3;
  localparam logic [2:0] REG_L1_B    = 3'd4;
  localparam logic [2:0] REG_L1_C    = 3'd5;
  localparam logic [2:0] REG_PRESENT = 3'd6;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DEGEN  = 2'd2,
    ST_BADSEL = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } lane_t;

  typedef struct packed {
    logic [31:0]        lat;
    logic signed [31:0] head;
    status_t            st;
  } res_t;

  typedef struct packed {
    status_t            st;
    logic               vert;
    logic               apos;
    logic signed [31:0] hd;
    logic signed [63:0] pax;
    logic signed [63:0] pby;
    logic [63:0]        paa;
    logic [63:0]        pbb;
    logic signed [31:0] c;
    logic signed [32:0] cx;
    logic signed [32:0] cy;
  } s1_t;

  typedef struct packed {
    status_t            st;
    logic               vert;
    logic               apos;
    logic signed [31:0] hd;
    logic [65:0]        num;
    logic [63:0]        n;
    logic signed [32:0] cx;
    logic signed [32:0] cy;
    logic [32:0]        cmx;
  } s2_t;

  typedef struct packed {
    status_t            st;
    logic               vert;
    logic               apos;
    logic signed [31:0] hd;
    logic [94:0]        d;
    logic [63:0]        n;
    logic signed [34:0] cx;
    logic signed [34:0] cy;
    logic [32:0]        cmx;
  } nrm_t;

  typedef struct packed {
    status_t            st;
    logic               vert;
    logic               apos;
    logic signed [31:0] hd;
    logic [94:0]        d;
    logic [63:0]        n;
    logic [63:0]        res;
    logic signed [34:0] cx;
    logic signed [34:0] cy;
    logic signed [31:0] z;
  } root_t;

  typedef struct packed {
    status_t            st;
    logic               sat;
    logic [31:0]        s;
    logic [32:0]        r;
    logic [31:0]        q;
    logic [31:0]        dlo;
    logic signed [31:0] hoff;
  } div_t;

  function automatic logic signed [31:0] atan_entry(input int unsigned i);
    logic signed [31:0] v;
    case (i)
      0: v = 32'sd210828714;
      1: v = 32'sd124459457;
      2: v = 32'sd65760959;
      3: v = 32'sd33381290;
      4: v = 32'sd16755422;
      5: v = 32'sd8385879;
      6: v = 32'sd4193963;
      7: v = 32'sd2097109;
      8: v = 32'sd1048571;
      9: v = 32'sd524287;
      default: v = 32'sd1 <<< (28 - i);
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/lte_core.sv -----
// Datapath pipeline: products, normalisation, square root with CORDIC, and long division.
// Depends on lte_pkg; advances all stages together on the enable from the top level.
`timescale 1ns / 1ps

module lte_core import lte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] heading,
  input  logic [7:0]         lane_select,
  input  lane_t              lane0,
  input  lane_t              lane1,
  input  logic [1:0]         present,
  output logic               vld_out,
  output res_t               res
);

  logic [PIPE_DEPTH-1:0] vld_r;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  nrm_t  nr_r [0:NORM_STAGES];
  nrm_t  nr0_nxt;
  root_t root_in;
  root_t rt_r [1:ROOT_STAGES];
  div_t  dv_r [0:DIV_STAGES];
  div_t  dv0_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
    end
  end

  assign vld_out = vld_r[PIPE_DEPTH-1];

  always_comb begin
    lane_t              ln;
    logic signed [32:0] ax;
    logic signed [32:0] bx;
    ln = lane_select[0] ? lane1 : lane0;
    ax = {ln.a[31], ln.a};
    bx = {ln.b[31], ln.b};
    if (lane_select > 8'd1) begin
      s1_nxt.st = ST_BADSEL;
    end else if (!present[lane_select[0]]) begin
      s1_nxt.st = ST_ABSENT;
    end else if (ln.a == 32'sd0 && ln.b == 32'sd0) begin
      s1_nxt.st = ST_DEGEN;
    end else begin
      s1_nxt.st = ST_OK;
    end
    s1_nxt.vert = (ln.b == 32'sd0);
    s1_nxt.apos = (ln.a > 32'sd0);
    s1_nxt.hd   = heading;
    s1_nxt.pax  = 64'(ln.a) * 64'(pos_x);
    s1_nxt.pby  = 64'(ln.b) * 64'(pos_y);
    s1_nxt.paa  = 64'(ln.a) * 64'(ln.a);
    s1_nxt.pbb  = 64'(ln.b) * 64'(ln.b);
    s1_nxt.c    = ln.c;
    s1_nxt.cx   = bx[32] ? -bx : bx;
    s1_nxt.cy   = (ln.b > 32'sd0) ? -ax : ax;
  end

  always_comb begin
    logic signed [32:0] ay;
    ay = s1_r.cy[32] ? -s1_r.cy : s1_r.cy;
    s2_nxt.st   = s1_r.st;
    s2_nxt.vert = s1_r.vert;
    s2_nxt.apos = s1_r.apos;
    s2_nxt.hd   = s1_r.hd;
    s2_nxt.num  = {{2{s1_r.pax[63]}}, s1_r.pax} + {{2{s1_r.pby[63]}}, s1_r.pby}
                + {{18{s1_r.c[31]}}, s1_r.c, 16'd0};
    s2_nxt.n    = s1_r.paa + s1_r.pbb;
    s2_nxt.cx   = s1_r.cx;
    s2_nxt.cy   = s1_r.cy;
    s2_nxt.cmx  = (s1_r.cx > ay) ? s1_r.cx : ay;
  end

  always_comb begin
    logic [65:0] mag;
    mag = s2_r.num[65] ? (~s2_r.num + 66'd1) : s2_r.num;
    nr0_nxt.st   = s2_r.st;
    nr0_nxt.vert = s2_r.vert;
    nr0_nxt.apos = s2_r.apos;
    nr0_nxt.hd   = s2_r.hd;
    nr0_nxt.d    = {31'd0, mag[63:0]};
    nr0_nxt.n    = s2_r.n;
    nr0_nxt.cx   = {{2{s2_r.cx[32]}}, s2_r.cx};
    nr0_nxt.cy   = {{2{s2_r.cy[32]}}, s2_r.cy};
    nr0_nxt.cmx  = s2_r.cmx;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r     <= s1_nxt;
      s2_r     <= s2_nxt;
      nr_r[0]  <= nr0_nxt;
    end
  end

  for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
    localparam int unsigned SH = 16 >> j;
    localparam int unsigned NW = 2 * SH;
    nrm_t nxt;
    always_comb begin
      nxt = nr_r[j];
      if (nr_r[j].n[63 -: NW] == '0) begin
        nxt.n = nr_r[j].n << NW;
        nxt.d = nr_r[j].d << SH;
      end
      if (nr_r[j].cmx < (33'd1 << (31 - SH))) begin
        nxt.cx  = nr_r[j].cx <<< SH;
        nxt.cy  = nr_r[j].cy <<< SH;
        nxt.cmx = nr_r[j].cmx << SH;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nr_r[j+1] <= nxt;
      end
    end
  end

  always_comb begin
    root_in.st   = nr_r[NORM_STAGES].st;
    root_in.vert = nr_r[NORM_STAGES].vert;
    root_in.apos = nr_r[NORM_STAGES].apos;
    root_in.hd   = nr_r[NORM_STAGES].hd;
    root_in.d    = nr_r[NORM_STAGES].d;
    root_in.n    = nr_r[NORM_STAGES].n;
    root_in.res  = '0;
    root_in.cx   = nr_r[NORM_STAGES].cx;
    root_in.cy   = nr_r[NORM_STAGES].cy;
    root_in.z    = '0;
  end

  for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_root
    localparam logic [63:0] ONE = 64'd1 << (62 - 2 * i);
    root_t cur;
    root_t nxt;
    if (i == 0) begin : g_first
      assign cur = root_in;
    end else begin : g_next
      assign cur = rt_r[i];
    end
    always_comb begin
      logic [63:0]        trial;
      logic signed [34:0] xc;
      logic signed [34:0] yc;
      nxt   = cur;
      trial = cur.res + ONE;
      xc    = cur.cx;
      yc    = cur.cy;
      if (cur.n >= trial) begin
        nxt.n   = cur.n - trial;
        nxt.res = (cur.res >> 1) + ONE;
      end else begin
        nxt.res = cur.res >> 1;
      end
      if (i < CORDIC_STEPS) begin
        if (yc > 35'sd0) begin
          nxt.cx = xc + (yc >>> i);
          nxt.cy = yc - (xc >>> i);
          nxt.z  = cur.z + atan_entry(i);
        end else begin
          nxt.cx = xc - (yc >>> i);
          nxt.cy = yc + (xc >>> i);
          nxt.z  = cur.z - atan_entry(i);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rt_r[i+1] <= nxt;
      end
    end
  end

  always_comb begin
    root_t              p;
    logic [62:0]        high;
    logic signed [31:0] slope;
    logic signed [34:0] dif;
    logic signed [34:0] half_w;
    logic signed [34:0] pi_w;
    p      = rt_r[ROOT_STAGES];
    high   = p.d[94:32];
    half_w = {{3{Q28_HALF_PI[31]}}, Q28_HALF_PI};
    pi_w   = {{3{Q28_PI[31]}}, Q28_PI};
    if (p.vert) begin
      slope = p.apos ? -Q28_HALF_PI : Q28_HALF_PI;
    end else begin
      slope = p.z;
    end
    dif = {{3{slope[31]}}, slope} - {{3{p.hd[31]}}, p.hd};
    if (dif < 35'sd0) begin
      dif = -dif;
    end
    if (dif > half_w) begin
      dif = pi_w - dif;
    end
    if (dif > 35'sd2147483647) begin
      dv0_nxt.hoff = 32'sh7FFF_FFFF;
    end else if (dif < -35'sd2147483648) begin
      dv0_nxt.hoff = 32'sh8000_0000;
    end else begin
      dv0_nxt.hoff = dif[31:0];
    end
    dv0_nxt.st  = p.st;
    dv0_nxt.s   = p.res[31:0];
    dv0_nxt.sat = (high >= {31'd0, p.res[31:0]});
    dv0_nxt.r   = high[32:0];
    dv0_nxt.q   = '0;
    dv0_nxt.dlo = p.d[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    localparam int unsigned BI = DIV_STAGES - 1 - i;
    div_t nxt;
    always_comb begin
      logic [32:0] rr;
      nxt = dv_r[i];
      rr  = {dv_r[i].r[31:0], dv_r[i].dlo[BI]};
      if (rr >= {1'b0, dv_r[i].s}) begin
        nxt.r = rr - {1'b0, dv_r[i].s};
        nxt.q = {dv_r[i].q[30:0], 1'b1};
      end else begin
        nxt.r = rr;
        nxt.q = {dv_r[i].q[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dv_r[i+1] <= nxt;
      end
    end
  end

  always_comb begin
    res.st = dv_r[DIV_STAGES].st;
    if (dv_r[DIV_STAGES].st != ST_OK) begin
      res.lat  = LAT_INVALID;
      res.head = HEAD_INVALID;
    end else begin
      res.lat  = dv_r[DIV_STAGES].sat ? 32'hFFFF_FFFF : dv_r[DIV_STAGES].q;
      res.head = dv_r[DIV_STAGES].hoff;
    end
  end

endmodule

// ----- rtl/lane_tracking_error.sv -----
// Top level of the lane tracking error block: register file, datapath and output skid stage.
// Depends on lte_pkg, lte_core and lane_tracking_error_macros.svh.
//
//   channel  handshake               word
//   in       in_valid / in_ready     pos_x, pos_y, heading, lane_select
//   out      out_valid / out_ready   lat_dist, head_err, status
//   cfg      psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// One word is accepted per cycle while in_ready is high; a result word passes 73 pipeline
// stages, then the output register, after its input word is accepted; the pipeline holds
// the 32-step square root and the 32-step quotient.
// Reset is synchronous and clears the valid bits and all configuration registers.
// A stalled output fills a one-word skid register, which then holds the pipeline.
`timescale 1ns / 1ps
`include "lane_tracking_error_macros.svh"

module lane_tracking_error import lte_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_heading,
  input  logic [7:0]         in_lane_select,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_lat_dist,
  output logic signed [31:0] out_head_err,
  output logic [1:0]         out_status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  lane_t      lane0_r, lane1_r;
  logic [1:0] present_r;
  logic       en, core_vld, arrive, take;
  res_t       core_res;
  res_t       out_r, out_nxt, skid_r, skid_nxt;
  logic       out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;
  logic       skid_quiet, err_word, ok_word;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane0_r   <= '0;
      lane1_r   <= '0;
      present_r <= '0;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_L0_A:    lane0_r.a <= pwdata;
        REG_L0_B:    lane0_r.b <= pwdata;
        REG_L0_C:    lane0_r.c <= pwdata;
        REG_L1_A:    lane1_r.a <= pwdata;
        REG_L1_B:    lane1_r.b <= pwdata;
        REG_L1_C:    lane1_r.c <= pwdata;
        REG_PRESENT: present_r <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_L0_A:    prdata = lane0_r.a;
      REG_L0_B:    prdata = lane0_r.b;
      REG_L0_C:    prdata = lane0_r.c;
      REG_L1_A:    prdata = lane1_r.a;
      REG_L1_B:    prdata = lane1_r.b;
      REG_L1_C:    prdata = lane1_r.c;
      REG_PRESENT: prdata = {30'd0, present_r};
      default:     prdata = '0;
    endcase
  end

  assign en       = !skid_valid_r;
  assign in_ready = en;

  lte_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_valid),
    .pos_x       (in_pos_x),
    .pos_y       (in_pos_y),
    .heading     (in_heading),
    .lane_select (in_lane_select),
    .lane0       (lane0_r),
    .lane1       (lane1_r),
    .present     (present_r),
    .vld_out     (core_vld),
    .res         (core_res)
  );

  assign arrive = en && core_vld;
  assign take   = out_valid_r && out_ready;

  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (take) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (arrive) begin
      if (!out_valid_r || take) begin
        out_nxt       = core_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = core_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_lat_dist = out_r.lat;
  assign out_head_err = out_r.head;
  assign out_status   = out_r.st;

  assign skid_quiet = !skid_valid_r && (!out_valid_r || out_ready);
  assign err_word   = out_valid_r && out_r.st != ST_OK;
  assign ok_word    = out_valid_r && out_r.st == ST_OK;

  `LTE_ASSERT_IMP(a_skid_needs_out, skid_valid_r, out_valid_r, "skid word without output word")
  `LTE_ASSERT_NXT(a_skid_fill, skid_quiet, !skid_valid_r, "skid filled without a stall")
  `LTE_ASSERT_IMP(a_error_lat, err_word, out_r.lat == LAT_INVALID, "wrong distance on error")
  `LTE_ASSERT_IMP(a_error_head, err_word, out_r.head == HEAD_INVALID, "wrong heading on error")
  `LTE_ASSERT_IMP(a_heading_range, ok_word, out_r.head <= Q28_HALF_PI, "heading past pi/2")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for lane_tracking_error: APB register writes, random words with
// random gaps and output stalls, checked against an in-bench fixed-point predictor.
// Depends on lte_pkg and the lane_tracking_error RTL only.
`timescale 1ns / 1ps

module tb_top;
  import lte_pkg::*;

  localparam int LATENCY = 74;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    logic [31:0]        lat;
    logic signed [31:0] head;
    logic [1:0]         st;
  } track_err_t;

  class err_board;
    track_err_t pending[$];
    int         mismatches;
    int         checked;

    function void note(track_err_t e);
      pending.push_back(e);
    endfunction

    function void check(logic [31:0] lat, logic signed [31:0] head, logic [1:0] st);
      track_err_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word lat=%h head=%h st=%0d", $time, lat, head, st);
        mismatches++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (lat !== e.lat) begin
        $display("%0t: lateral offset expected %h actual %h", $time, e.lat, lat);
        mismatches++;
      end
      if (head !== e.head) begin
        $display("%0t: heading offset expected %h actual %h", $time, e.head, head);
        mismatches++;
      end
      if (st !== e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, st);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_pos_x = '0;
  logic signed [31:0] in_pos_y = '0;
  logic signed [31:0] in_heading = '0;
  logic [7:0] in_lane_select = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_lat_dist;
  logic signed [31:0] out_head_err;
  logic [1:0] out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lane_tracking_error uut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  err_board board = new();
  logic signed [31:0] lane_a[2], lane_b[2], lane_c[2];
  logic [1:0] present;
  int idle_cycles;
  bit stall_long;
  bit random_on;

  function automatic logic signed [63:0] asr64(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] path_slope(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] x, y, z, mx, ay, nx, ny;
    z = 0;
    if (b == 0) return (a > 0) ? -64'sd421657428 : 64'sd421657428;
    x = (b > 0) ? b : -b;
    y = (b > 0) ? -a : a;
    forever begin
      ay = (y >= 0) ? y : -y;
      mx = (x > ay) ? x : ay;
      if (mx >= (64'sd1 <<< 30)) break;
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (y > 0) begin
        nx = x + asr64(y, i);
        ny = y - asr64(x, i);
        z = z + atan_entry(i);
      end else begin
        nx = x - asr64(y, i);
        ny = y + asr64(x, i);
        z = z - atan_entry(i);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] r, one;
    r = 0;
    one = 64'd1 << 62;
    while (one > n) one = one >> 2;
    while (one != 0) begin
      if (n >= r + one) begin
        n = n - (r + one);
        r = (r >> 1) + one;
      end else begin
        r = r >> 1;
      end
      one = one >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] distance(logic signed [63:0] a, logic signed [63:0] b,
                                           logic signed [63:0] c, logic signed [63:0] x,
                                           logic signed [63:0] y);
    logic signed [127:0] sum;
    logic [127:0] m;
    logic [63:0] n, s;
    logic [127:0] r, q;
    int k;
    sum = 128'(a * x) + 128'(b * y) + 128'(c * 65536);
    m = (sum < 0) ? -sum : sum;
    n = 64'(a * a) + 64'(b * b);
    k = 0;
    while (n < (64'd1 << 62)) begin
      n = n << 2;
      k++;
    end
    s = root64(n);
    r = 0;
    q = 0;
    for (int i = 0; i < 64 + k; i++) begin
      r = (r << 1) | ((i < 64) ? ((m >> (63 - i)) & 1) : 0);
      q = q << 1;
      if (r >= s) begin
        r = r - s;
        q = q | 1;
      end
      if (q > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic track_err_t predict_error(logic signed [31:0] px, logic signed [31:0] py,
                                               logic signed [31:0] hd, logic [7:0] sel);
    track_err_t e;
    logic signed [63:0] a, b, c, d;
    e.st = ST_OK;
    if (sel > 1) e.st = ST_BADSEL;
    else if (!present[sel]) e.st = ST_ABSENT;
    else if (lane_a[sel] == 0 && lane_b[sel] == 0) e.st = ST_DEGEN;
    if (e.st != ST_OK) begin
      e.lat = LAT_INVALID;
      e.head = HEAD_INVALID;
      return e;
    end
    a = lane_a[sel];
    b = lane_b[sel];
    c = lane_c[sel];
    d = path_slope(a, b) - hd;
    if (d < 0) d = -d;
    if (d > Q28_HALF_PI) d = Q28_PI - d;
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    e.head = d[31:0];
    e.lat = distance(a, b, c, px, py);
    return e;
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_L0_A: lane_a[0] = v;
      REG_L0_B: lane_b[0] = v;
      REG_L0_C: lane_c[0] = v;
      REG_L1_A: lane_a[1] = v;
      REG_L1_B: lane_b[1] = v;
      REG_L1_C: lane_c[1] = v;
      REG_PRESENT: present = v[1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_lanes(logic [31:0] a0, logic [31:0] b0, logic [31:0] c0,
                           logic [31:0] a1, logic [31:0] b1, logic [31:0] c1,
                           logic [1:0] pr);
    reg_write(REG_L0_A, a0);
    reg_write(REG_L0_B, b0);
    reg_write(REG_L0_C, c0);
    reg_write(REG_L1_A, a1);
    reg_write(REG_L1_B, b1);
    reg_write(REG_L1_C, c1);
    reg_write(REG_PRESENT, pr);
  endtask

  task automatic send_word(logic [31:0] px, logic [31:0] py, logic [31:0] hd, logic [7:0] sel);
    in_valid <= 1'b1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_heading <= hd;
    in_lane_select <= sel;
    do @(posedge clk); while (!in_ready);
    board.note(predict_error(px, py, hd, sel));
  endtask

  task automatic pause_input();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 65536 * 200) - 65536 * 100;
      2: return {{16{1'b0}}, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [7:0] rand_sel();
    int p;
    p = $urandom_range(0, 19);
    if (p < 9) return 8'd0;
    if (p < 18) return 8'd1;
    return 8'($urandom_range(2, 255));
  endfunction

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && left > 0; i++, left--) begin
        send_word(rand_coord(), rand_coord(), $urandom(), rand_sel());
      end
      if ($urandom_range(0, 2) != 0) pause_input();
    end
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check(out_lat_dist, out_head_err, out_status);
  end

  always @(posedge clk) begin
    if (stall_long) out_ready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: out_ready <= ($urandom_range(0, 3) != 0);
      1: out_ready <= 1'b1;
      2: out_ready <= ($urandom_range(0, 1) != 0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    stall_long <= 1'b0;
    wait (random_on);
    repeat (100) @(posedge clk);
    stall_long <= 1'b1;
    repeat (300) @(posedge clk);
    stall_long <= 1'b0;
  end

  initial begin
    random_on = 1'b0;
    lane_a = '{0, 0};
    lane_b = '{0, 0};
    lane_c = '{0, 0};
    present = 2'b00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: lanes absent, then an unknown selector.
    send_word(32'h0001_0000, 32'h0002_0000, 32'h0, 8'd0);
    send_word(32'h0, 32'h0, 32'h0, 8'd1);
    send_word(32'h0, 32'h0, 32'h0, 8'd255);
    in_valid <= 1'b0;
    drain();

    // Lane 0 vertical (b zero), lane 1 degenerate.
    set_lanes(32'h0001_0000, 32'h0, 32'hFFFF_0000, 32'h0, 32'h0, 32'h1234, 2'b11);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 8'd0);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0);
    send_word(32'h0, 32'h0, 32'h0, 8'd1);
    send_word(32'hFFFF_FFFF, 32'h1, 32'h1921_FB54, 8'd2);
    in_valid <= 1'b0;
    drain();

    // Extreme coefficients to saturate distance and heading.
    set_lanes(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000,
              2'b10);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'd1);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'd1);
    send_word(32'h0, 32'h0, 32'h0, 8'd1);
    in_valid <= 1'b0;
    drain();
    set_lanes(32'h1, 32'h1, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 2'b01);

    random_on = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5)
        set_lanes(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                  2'b11);
      else
        set_lanes($urandom_range(0, 1) ? $urandom() : $urandom_range(0, 65536 * 4),
                  $urandom_range(0, 3) == 0 ? 32'h0 : $urandom(),
                  $urandom(), $urandom(),
                  $urandom_range(0, 7) == 0 ? 32'h0 : $urandom_range(0, 65536 * 8) - 65536 * 4,
                  $urandom(), ph == 0 ? 2'b11 : 2'($urandom()));
      random_phase(280);
      drain();
    end

    $display("Checked %0d result words over reset, error, vertical, saturating and random",
             board.checked);
    $display("lane settings, with bursty input and stalled output.");
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/lte_pkg.sv
rtl/lte_core.sv
rtl/lane_tracking_error.sv
dv/tb_top.sv
